[src/tvam_pkg.sv]
// ----------------------------------------------------------------------------
// tvam_pkg
// Shared types, constants and tables for the thrust vector to actuator map.
// ----------------------------------------------------------------------------
package tvam_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned AngTabLen      = 24;
  localparam int unsigned QueueDepth     = 2;

  localparam logic [15:0] ThrustKnee = 16'd1562;
  localparam logic signed [31:0] Deg180Q16 = 32'sd11796480;
  localparam logic signed [47:0] Deg90Q28  = 48'sd24159191040;
  localparam logic [16:0] DriveFull = 17'd65536;

  localparam int unsigned AddrW = 6;

  typedef enum logic [2:0] {
    RegRollGain    = 3'd0,
    RegRollOffset  = 3'd1,
    RegPitchGain   = 3'd2,
    RegPitchOffset = 3'd3,
    RegRollLimits  = 3'd4,
    RegPitchLimits = 3'd5,
    RegCubicCoefs  = 3'd6,
    RegLinearCoefs = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] force_x;
    logic signed [15:0] force_y;
    logic signed [15:0] force_z;
  } req_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic        [16:0] valve_drive;
    logic        [15:0] total_thrust;
  } rsp_t;

  // Classified request handed from front to back.
  typedef struct packed {
    logic [33:0]        sq;       // sum of squares
    logic signed [16:0] roll_num;
    logic signed [16:0] roll_den;
    logic signed [16:0] pitch_num;
    logic signed [16:0] pitch_den;
  } job_t;

  typedef struct packed {
    logic signed [15:0] roll_gain;
    logic signed [15:0] roll_offset;
    logic signed [15:0] pitch_gain;
    logic signed [15:0] pitch_offset;
    logic        [31:0] roll_limits;
    logic        [31:0] pitch_limits;
    logic        [63:0] cubic_coefs;
    logic        [31:0] linear_coefs;
  } cfg_t;

  function automatic logic signed [31:0] atan_q16(input logic [4:0] i);
    logic signed [31:0] r;
    case (i)
      5'd0: r = 32'sd2949120;  5'd1: r = 32'sd1740967; 5'd2: r = 32'sd919879;
      5'd3: r = 32'sd466945;   5'd4: r = 32'sd234379;  5'd5: r = 32'sd117266;
      5'd6: r = 32'sd58665;    5'd7: r = 32'sd29335;   5'd8: r = 32'sd14668;
      5'd9: r = 32'sd7334;     5'd10: r = 32'sd3667;   5'd11: r = 32'sd1833;
      5'd12: r = 32'sd917;     5'd13: r = 32'sd458;    5'd14: r = 32'sd229;
      5'd15: r = 32'sd115;     5'd16: r = 32'sd57;     5'd17: r = 32'sd29;
      5'd18: r = 32'sd14;      5'd19: r = 32'sd7;      5'd20: r = 32'sd4;
      5'd21: r = 32'sd2;       5'd22: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

[src/tvam_regs.sv]
// ----------------------------------------------------------------------------
// tvam_regs
// APB register file holding calibration, limits and valve law coefficients.
// ----------------------------------------------------------------------------
module tvam_regs import tvam_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;
  logic [2:0] idx;

  assign idx    = paddr[AddrW-1:3];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.roll_gain    <= 16'sd4096;
      cfg_q.roll_offset  <= '0;
      cfg_q.pitch_gain   <= 16'sd4096;
      cfg_q.pitch_offset <= '0;
      cfg_q.roll_limits  <= 32'h5A00_0000;
      cfg_q.pitch_limits <= 32'h5A00_0000;
      cfg_q.cubic_coefs  <= '0;
      cfg_q.linear_coefs <= '0;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      case (reg_idx_e'(idx))
        RegRollGain:    cfg_q.roll_gain    <= pwdata[15:0];
        RegRollOffset:  cfg_q.roll_offset  <= pwdata[15:0];
        RegPitchGain:   cfg_q.pitch_gain   <= pwdata[15:0];
        RegPitchOffset: cfg_q.pitch_offset <= pwdata[15:0];
        RegRollLimits:  cfg_q.roll_limits  <= pwdata[31:0];
        RegPitchLimits: cfg_q.pitch_limits <= pwdata[31:0];
        RegCubicCoefs:  cfg_q.cubic_coefs  <= pwdata;
        RegLinearCoefs: cfg_q.linear_coefs <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'd0) begin
      case (reg_idx_e'(idx))
        RegRollGain:    prdata = {48'd0, cfg_q.roll_gain};
        RegRollOffset:  prdata = {48'd0, cfg_q.roll_offset};
        RegPitchGain:   prdata = {48'd0, cfg_q.pitch_gain};
        RegPitchOffset: prdata = {48'd0, cfg_q.pitch_offset};
        RegRollLimits:  prdata = {32'd0, cfg_q.roll_limits};
        RegPitchLimits: prdata = {32'd0, cfg_q.pitch_limits};
        RegCubicCoefs:  prdata = cfg_q.cubic_coefs;
        RegLinearCoefs: prdata = {32'd0, cfg_q.linear_coefs};
        default:        prdata = '0;
      endcase
    end
  end

endmodule

[src/tvam_front.sv]
// ----------------------------------------------------------------------------
// tvam_front
// Accept a request, register it, form squares and angle operands.
// ----------------------------------------------------------------------------
module tvam_front import tvam_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic job_valid_o,
  input  logic job_stall_i,
  output job_t job_o
);

  // stage 1: capture request
  logic s1_valid_q;
  req_t s1_q;
  // stage 2: squares
  logic s2_valid_q;
  logic [31:0] sqx_q, sqy_q, sqz_q;
  req_t s2_q;
  logic s3_valid_q;
  job_t job_q;

  logic adv3, adv2, adv1;
  assign adv3 = !s3_valid_q || !job_stall_i;
  assign adv2 = !s2_valid_q || adv3;
  assign adv1 = !s1_valid_q || adv2;
  assign in_stall_o = !adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (adv1) s1_valid_q <= in_valid_i;
      if (adv2) s2_valid_q <= s1_valid_q;
      if (adv3) s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) s1_q <= in_req_i;
    if (adv2 && s1_valid_q) begin
      s2_q  <= s1_q;
      sqx_q <= 32'(s1_q.force_x * s1_q.force_x);
      sqy_q <= 32'(s1_q.force_y * s1_q.force_y);
      sqz_q <= 32'(s1_q.force_z * s1_q.force_z);
    end
    if (adv3 && s2_valid_q) begin
      job_q.sq        <= 34'(sqx_q) + 34'(sqy_q) + 34'(sqz_q);
      job_q.roll_num  <= -17'(s2_q.force_y);
      job_q.roll_den  <= 17'(s2_q.force_z);
      job_q.pitch_num <= 17'(s2_q.force_x);
      job_q.pitch_den <= 17'(s2_q.force_z);
    end
  end

  assign job_valid_o = s3_valid_q;
  assign job_o       = job_q;

endmodule

[src/tvam_queue.sv]
// ----------------------------------------------------------------------------
// tvam_queue
// Short FIFO decoupling the front from the back.
// ----------------------------------------------------------------------------
module tvam_queue import tvam_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_stall_o,
  input  job_t wr_i,
  output logic rd_valid_o,
  input  logic rd_stall_i,
  output job_t rd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic wr, rd;

  assign wr_stall_o = (cnt_q == (PtrW+1)'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign wr = wr_valid_i && !wr_stall_o;
  assign rd = rd_valid_o && !rd_stall_i;
  assign rd_o = mem_q[rp_q];

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= inc(wp_q);
      if (rd) rp_q <= inc(rp_q);
      cnt_q <= cnt_q + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_i;
  end

endmodule

[src/tvam_back.sv]
// ----------------------------------------------------------------------------
// tvam_back
// Iterative square root and two CORDIC lanes, then calibration and valve law.
// ----------------------------------------------------------------------------
module tvam_back import tvam_pkg::*; #(
  parameter int unsigned CordicSteps = CordicStepsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic job_valid_i,
  output logic job_stall_o,
  input  job_t job_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_o
);

  localparam int unsigned Steps = (CordicSteps < AngTabLen) ? CordicSteps : AngTabLen;
  localparam int unsigned Iters = (Steps > 17) ? Steps : 17;
  localparam int unsigned CntW  = $clog2(Iters + 1);

  typedef enum logic [2:0] {
    StIdle, StRun, StCal, StPoly1, StPoly2, StPoly3, StDone
  } state_e;

  state_e state_q;
  logic [CntW-1:0] cnt_q;

  // square root
  logic [33:0] rem_q;
  logic [33:0] root_q;
  logic [33:0] bit_q;
  // cordic lanes: 0 roll, 1 pitch
  logic signed [27:0] cx_q [2];
  logic signed [27:0] cy_q [2];
  logic signed [31:0] acc_q [2];
  logic               zero_q [2];
  logic               den_neg_q [2];
  // post
  logic [15:0] t_q;
  logic signed [15:0] ang_q [2];
  logic signed [47:0] pa_q, pb_q;
  logic signed [63:0] sum_q;
  logic               cub_q;
  rsp_t out_q;
  logic out_valid_q;
  logic out_load;

  logic signed [16:0] nums [2];
  logic signed [16:0] dens [2];
  assign nums[0] = job_i.roll_num;
  assign dens[0] = job_i.roll_den;
  assign nums[1] = job_i.pitch_num;
  assign dens[1] = job_i.pitch_den;

  assign job_stall_o = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign out_load    = (state_q == StDone) && (!out_valid_q || !out_stall_i);

  function automatic logic signed [15:0] calib(input logic signed [31:0] a,
      input logic signed [15:0] g, input logic signed [15:0] o, input logic [31:0] lim);
    logic signed [63:0] v;
    logic signed [63:0] q;
    logic signed [15:0] hi, lo, r;
    v  = 64'(a) * 64'(g) + (64'(o) <<< 21) + 64'(Deg90Q28) + (64'sd1 <<< 20);
    q  = v >>> 21;
    hi = lim[31:16];
    lo = lim[15:0];
    if (q > 64'sd32767) q = 64'sd32767;
    if (q < -64'sd32768) q = -64'sd32768;
    r = 16'(q);
    if (r >= hi) r = hi;
    if (r <= lo) r = lo;
    return r;
  endfunction

  logic [33:0] rb;
  logic signed [15:0] c3, c2, c1, c0, k, b;
  assign rb = root_q + bit_q;
  assign c3 = cfg_i.cubic_coefs[63:48];
  assign c2 = cfg_i.cubic_coefs[47:32];
  assign c1 = cfg_i.cubic_coefs[31:16];
  assign c0 = cfg_i.cubic_coefs[15:0];
  assign k  = cfg_i.linear_coefs[31:16];
  assign b  = cfg_i.linear_coefs[15:0];

  logic signed [63:0] drv;
  always_comb begin
    if (cub_q) drv = (sum_q + (64'sd1 <<< 19)) >>> 20;
    else       drv = (sum_q + 64'sd8) >>> 4;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (out_load)                     out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            rem_q  <= job_i.sq;
            root_q <= '0;
            bit_q  <= 34'd1 << 32;
            for (int l = 0; l < 2; l++) begin
              zero_q[l]    <= (nums[l] == '0);
              den_neg_q[l] <= (dens[l] < 0);
              if (dens[l] < 0) begin
                cx_q[l]  <= -(28'(dens[l]) <<< 8);
                cy_q[l]  <= -(28'(nums[l]) <<< 8);
                acc_q[l] <= (nums[l] > 0) ? Deg180Q16 : -Deg180Q16;
              end else begin
                cx_q[l]  <= 28'(dens[l]) <<< 8;
                cy_q[l]  <= 28'(nums[l]) <<< 8;
                acc_q[l] <= '0;
              end
            end
            cnt_q   <= '0;
            state_q <= StRun;
          end
        end
        StRun: begin
          // one root digit and one rotation per lane, each only while its own count lasts
          if (cnt_q < CntW'(17)) begin
            if (rem_q >= rb) begin
              rem_q  <= rem_q - rb;
              root_q <= (root_q >> 1) + bit_q;
            end else begin
              root_q <= root_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end
          if (cnt_q < CntW'(Steps)) begin
            for (int l = 0; l < 2; l++) begin
              if (cy_q[l] > 0) begin
                cx_q[l]  <= cx_q[l] + (cy_q[l] >>> cnt_q);
                cy_q[l]  <= cy_q[l] - (cx_q[l] >>> cnt_q);
                acc_q[l] <= acc_q[l] + atan_q16(5'(cnt_q));
              end else begin
                cx_q[l]  <= cx_q[l] - (cy_q[l] >>> cnt_q);
                cy_q[l]  <= cy_q[l] + (cx_q[l] >>> cnt_q);
                acc_q[l] <= acc_q[l] - atan_q16(5'(cnt_q));
              end
            end
          end
          if (cnt_q == CntW'(Iters - 1)) state_q <= StCal;
          cnt_q <= cnt_q + 1'b1;
        end
        StCal: begin
          t_q <= 16'((rem_q > root_q) ? root_q + 1'b1 : root_q);
          for (int l = 0; l < 2; l++) begin
            if (zero_q[l]) acc_q[l] <= den_neg_q[l] ? Deg180Q16 : '0;
          end
          state_q <= StPoly1;
        end
        StPoly1: begin
          ang_q[0] <= calib(acc_q[0], cfg_i.roll_gain, cfg_i.roll_offset,
                            cfg_i.roll_limits);
          ang_q[1] <= calib(acc_q[1], cfg_i.pitch_gain, cfg_i.pitch_offset,
                            cfg_i.pitch_limits);
          cub_q <= (t_q <= ThrustKnee);
          // t*t and linear/low terms
          pa_q  <= 48'(32'(t_q) * 32'(t_q));
          pb_q  <= 48'(c1) * 48'(t_q);
          state_q <= StPoly2;
        end
        StPoly2: begin
          if (cub_q) begin
            sum_q <= 64'(c2) * 64'(pa_q) * 64'sd256 + (64'(pb_q) <<< 16)
                   + (64'(c0) <<< 24);
            pa_q  <= 48'(pa_q * 48'(t_q));
          end else begin
            sum_q <= 64'(k) * 64'(t_q) + (64'(b) <<< 8);
          end
          state_q <= StPoly3;
        end
        StPoly3: begin
          if (cub_q) sum_q <= sum_q + 64'(c3) * 64'(pa_q);
          state_q <= StDone;
        end
        StDone: begin
          if (out_load) begin
            out_q.roll_angle   <= ang_q[0];
            out_q.pitch_angle  <= ang_q[1];
            out_q.total_thrust <= t_q;
            if (drv > $signed(64'(DriveFull))) out_q.valve_drive <= DriveFull;
            else if (drv < 0)                  out_q.valve_drive <= '0;
            else                               out_q.valve_drive <= 17'(drv);
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

[src/thrust_vector_to_actuator_map_core.sv]
// ----------------------------------------------------------------------------
// thrust_vector_to_actuator_map_core
// Thrust vector to roll/pitch servo angles, valve drive and total thrust.
// ----------------------------------------------------------------------------
// From request accept to result valid: 3 front stages, the queue, then the
// back part. The back takes a new request only after the previous result has
// left it; the square root and the two CORDIC lanes share one iteration loop.
// Reset: asynchronous, active low; registers take their documented values,
// queue and pipeline empty.
module thrust_vector_to_actuator_map_core import tvam_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  req_t             in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rsp_t             out_rsp_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  cfg_t cfg;
  logic f_valid, f_stall, b_valid, b_stall;
  job_t f_job, b_job;

  // Register file
  tvam_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  // Front: accept and classify each request
  tvam_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i,
    .job_valid_o(f_valid), .job_stall_i(f_stall), .job_o(f_job)
  );

  // Queue: hold classified requests while the back is busy
  tvam_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_stall_o(f_stall), .wr_i(f_job),
    .rd_valid_o(b_valid), .rd_stall_i(b_stall), .rd_o(b_job)
  );

  // Back: iterate and drive the result register
  tvam_back #(.CordicSteps(CORDIC_STEPS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .job_valid_i(b_valid), .job_stall_o(b_stall),
    .job_i(b_job), .out_valid_o, .out_stall_i, .out_o(out_rsp_o)
  );

endmodule

[src/tvam_checker.sv]
// ----------------------------------------------------------------------------
// tvam_checker
// Port-level checks on the thrust vector to actuator map.
// ----------------------------------------------------------------------------
module tvam_checker import tvam_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input rsp_t out_rsp_o
);

  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.valve_drive <= DriveFull) else $error("drive range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result dropped");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o) else $error("result during reset");

  a_stall_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> !$isunknown(in_stall_o)) else $error("unknown request stall");

endmodule

bind thrust_vector_to_actuator_map_core tvam_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_rsp_o
);
